@@ rtl/core/knnmc_pkg.sv @@
// Shared types and constants for the nearest-neighbor material classifier.
// Holds the labelled reference table, field widths and class codes.
// No dependencies; every other file of the block imports this package.
package knnmc_pkg;

	localparam int WEIGHT_W   = 17;
	localparam int COND_W     = 17;
	localparam int IR_W       = 14;
	localparam int RAD_W      = 14;
	localparam int CLASS_W    = 3;
	localparam int TABLE_SIZE = 10;
	localparam int NUM_CLASSES = 5;

	// Squares of each feature difference and their sum; the sum stays below 2^36.
	localparam int SQ_WIDE_W   = 2 * WEIGHT_W;
	localparam int SQ_NARROW_W = 2 * IR_W;
	localparam int MAG_SQ_W    = 14;
	localparam int DIST_W      = 36;

	// The magnetic flag is in whole units, so a mismatch contributes 100 squared.
	localparam logic [MAG_SQ_W-1:0] MAG_SQ = 14'd10000;

	typedef enum logic [CLASS_W-1:0] {
		CLASS_FERROUS     = 3'd0,
		CLASS_NON_FERROUS = 3'd1,
		CLASS_RECYCLABLE  = 3'd2,
		CLASS_E_WASTE     = 3'd3,
		CLASS_HAZARDOUS   = 3'd4
	} material_class_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [COND_W-1:0]   conductivity;
		logic                magnetic;
		logic [IR_W-1:0]     ir_purity;
		logic [RAD_W-1:0]    radiation;
	} query_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic [COND_W-1:0]   conductivity;
		logic                magnetic;
		logic [IR_W-1:0]     ir_purity;
		logic [RAD_W-1:0]    radiation;
		material_class_t     cls;
	} ref_sample_t;

	localparam ref_sample_t REF_TABLE [TABLE_SIZE] = '{
		'{17'd30000, 17'd1000, 1'b1, 14'd5000, 14'd0,    CLASS_FERROUS},
		'{17'd45000, 17'd1200, 1'b1, 14'd5500, 14'd0,    CLASS_FERROUS},
		'{17'd8000,  17'd4000, 1'b0, 14'd8500, 14'd0,    CLASS_NON_FERROUS},
		'{17'd12000, 17'd3800, 1'b0, 14'd9000, 14'd0,    CLASS_NON_FERROUS},
		'{17'd10000, 17'd5500, 1'b0, 14'd9500, 14'd0,    CLASS_RECYCLABLE},
		'{17'd15000, 17'd6000, 1'b0, 14'd9700, 14'd0,    CLASS_RECYCLABLE},
		'{17'd20000, 17'd1500, 1'b0, 14'd3000, 14'd5000, CLASS_E_WASTE},
		'{17'd25000, 17'd2000, 1'b0, 14'd3500, 14'd7000, CLASS_E_WASTE},
		'{17'd5000,  17'd500,  1'b0, 14'd2000, 14'd9000, CLASS_HAZARDOUS},
		'{17'd6000,  17'd700,  1'b0, 14'd2500, 14'd8500, CLASS_HAZARDOUS}
	};

endpackage

@@ rtl/core/knnmc_dist.sv @@
// Squared distance from the registered query to one reference sample.
// Two stages: per-feature squares, then their sum. Depends on knnmc_pkg.
module knnmc_dist (
	input  logic                         clk,
	input  knnmc_pkg::query_t            query_s1,
	input  knnmc_pkg::ref_sample_t       ref_sample,
	output logic [knnmc_pkg::DIST_W-1:0] dist_s3
);
	import knnmc_pkg::*;

	logic [WEIGHT_W-1:0]    diff_w;
	logic [COND_W-1:0]      diff_c;
	logic [IR_W-1:0]        diff_i;
	logic [RAD_W-1:0]       diff_r;
	logic [SQ_WIDE_W-1:0]   sq_w_s2;
	logic [SQ_WIDE_W-1:0]   sq_c_s2;
	logic [SQ_NARROW_W-1:0] sq_i_s2;
	logic [SQ_NARROW_W-1:0] sq_r_s2;
	logic [MAG_SQ_W-1:0]    sq_m_s2;

	always_comb begin
		diff_w = (query_s1.weight > ref_sample.weight) ?
			query_s1.weight - ref_sample.weight : ref_sample.weight - query_s1.weight;
		diff_c = (query_s1.conductivity > ref_sample.conductivity) ?
			query_s1.conductivity - ref_sample.conductivity :
			ref_sample.conductivity - query_s1.conductivity;
		diff_i = (query_s1.ir_purity > ref_sample.ir_purity) ?
			query_s1.ir_purity - ref_sample.ir_purity :
			ref_sample.ir_purity - query_s1.ir_purity;
		diff_r = (query_s1.radiation > ref_sample.radiation) ?
			query_s1.radiation - ref_sample.radiation :
			ref_sample.radiation - query_s1.radiation;
	end

	always_ff @(posedge clk) begin
		sq_w_s2 <= SQ_WIDE_W'(diff_w) * SQ_WIDE_W'(diff_w);
		sq_c_s2 <= SQ_WIDE_W'(diff_c) * SQ_WIDE_W'(diff_c);
		sq_i_s2 <= SQ_NARROW_W'(diff_i) * SQ_NARROW_W'(diff_i);
		sq_r_s2 <= SQ_NARROW_W'(diff_r) * SQ_NARROW_W'(diff_r);
		sq_m_s2 <= (query_s1.magnetic != ref_sample.magnetic) ? MAG_SQ : '0;
	end

	always_ff @(posedge clk) begin
		dist_s3 <= DIST_W'(sq_w_s2) + DIST_W'(sq_c_s2) + DIST_W'(sq_i_s2)
			+ DIST_W'(sq_r_s2) + DIST_W'(sq_m_s2);
	end

endmodule

@@ rtl/core/knnmc_rank.sv @@
// Ranks every reference distance against all others and marks the K nearest.
// Ties go to the lower table index. Depends on knnmc_pkg.
module knnmc_rank #(
	parameter int N_REF = 10,
	parameter int K_EFF = 3
) (
	input  logic                         clk,
	input  logic [knnmc_pkg::DIST_W-1:0] dist_s3 [N_REF],
	output logic [N_REF-1:0]             vote_mask_s4
);
	import knnmc_pkg::*;

	localparam int RANK_W = $clog2(N_REF + 1);

	logic [N_REF-1:0]  nearer [N_REF];
	logic [RANK_W-1:0] rank   [N_REF];

	// nearer[i][j] says reference j sits ahead of reference i in the ordering.
	always_comb begin
		for (int i = 0; i < N_REF; i++) begin
			for (int j = 0; j < N_REF; j++) begin
				nearer[i][j] = (j != i) && ((dist_s3[j] < dist_s3[i]) ||
					((dist_s3[j] == dist_s3[i]) && (j < i)));
			end
		end
	end

	always_comb begin
		for (int i = 0; i < N_REF; i++) begin
			rank[i] = '0;
			for (int j = 0; j < N_REF; j++) begin
				rank[i] = rank[i] + RANK_W'(nearer[i][j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < N_REF; i++) begin
			vote_mask_s4[i] <= rank[i] < RANK_W'(K_EFF);
		end
	end

endmodule

@@ rtl/core/knnmc_vote.sv @@
// Tallies the votes of the selected references per class and picks the winner.
// Equal tallies go to the lowest class code. Depends on knnmc_pkg.
module knnmc_vote #(
	parameter int N_REF = 10
) (
	input  logic                          clk,
	input  logic [N_REF-1:0]              vote_mask_s4,
	output logic [knnmc_pkg::CLASS_W-1:0] material_class_s5
);
	import knnmc_pkg::*;

	localparam int VOTE_W = $clog2(N_REF + 1);

	logic [VOTE_W-1:0]  tally [NUM_CLASSES];
	logic [VOTE_W-1:0]  best_tally;
	logic [CLASS_W-1:0] best_class;

	always_comb begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			tally[c] = '0;
			for (int i = 0; i < N_REF; i++) begin
				tally[c] = tally[c] + VOTE_W'(vote_mask_s4[i] &&
					(REF_TABLE[i].cls == CLASS_W'(c)));
			end
		end
	end

	// A strict compare keeps the earlier, higher-priority class on a tie.
	always_comb begin
		best_class = CLASS_FERROUS;
		best_tally = tally[0];
		for (int c = 1; c < NUM_CLASSES; c++) begin
			if (tally[c] > best_tally) begin
				best_class = CLASS_W'(c);
				best_tally = tally[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		material_class_s5 <= best_class;
	end

endmodule

@@ rtl/core/knn_material_classifier_top.sv @@
// Nearest-neighbor material classifier: one query in, one class code out.
// done rises once a taken request has passed the input, squares, sum, ranking and vote registers.
// Throughput: one request per cycle; the pipeline never stalls, so busy stays low.
// Depth is set by input register, squares, distance sum, ranking and vote stages.
// Reset (arst_n low) clears every stage's valid bit; payload registers are not reset.
// The receiver cannot stall: each result is shown for one cycle with done high.
module knn_material_classifier_top #(
	parameter int NUM_REFERENCES = 10,
	parameter int K_NEAREST      = 3
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [knnmc_pkg::WEIGHT_W-1:0]  weight_hundredths,
	input  logic [knnmc_pkg::COND_W-1:0]    conductivity_hundredths,
	input  logic                            is_magnetic,
	input  logic [knnmc_pkg::IR_W-1:0]      ir_purity_hundredths,
	input  logic [knnmc_pkg::RAD_W-1:0]     radiation_hundredths,
	output logic                            done,
	output logic [knnmc_pkg::CLASS_W-1:0]   material_class
);
	import knnmc_pkg::*;

	localparam int N_REF = (NUM_REFERENCES < TABLE_SIZE) ? NUM_REFERENCES : TABLE_SIZE;
	localparam int K_EFF = (K_NEAREST < N_REF) ? K_NEAREST : N_REF;

	logic              accept;
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic              valid_s4;
	logic              valid_s5;
	query_t            query_s1;
	logic [DIST_W-1:0] dist_s3 [N_REF];
	logic [N_REF-1:0]  vote_mask_s4;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign done   = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			query_s1.weight       <= weight_hundredths;
			query_s1.conductivity <= conductivity_hundredths;
			query_s1.magnetic     <= is_magnetic;
			query_s1.ir_purity    <= ir_purity_hundredths;
			query_s1.radiation    <= radiation_hundredths;
		end
	end

	for (genvar g = 0; g < N_REF; g++) begin : g_dist
		knnmc_dist u_dist (
			.clk        (clk),
			.query_s1   (query_s1),
			.ref_sample (REF_TABLE[g]),
			.dist_s3    (dist_s3[g])
		);
	end

	knnmc_rank #(
		.N_REF (N_REF),
		.K_EFF (K_EFF)
	) u_rank (
		.clk          (clk),
		.dist_s3      (dist_s3),
		.vote_mask_s4 (vote_mask_s4)
	);

	knnmc_vote #(
		.N_REF (N_REF)
	) u_vote (
		.clk               (clk),
		.vote_mask_s4      (vote_mask_s4),
		.material_class_s5 (material_class)
	);

	// Every accepted request comes out with done once it has passed every pipeline stage.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##5 done)
		else $error("request did not complete after five cycles");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result strobe without a matching request");

	// The ranking is a permutation, so exactly K_EFF references vote.
	a_vote_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> ($countones(vote_mask_s4) == K_EFF))
		else $error("wrong number of voting references");

	a_class_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (material_class <= CLASS_HAZARDOUS))
		else $error("class code out of range");

endmodule
